>>> design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property p must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, p, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);

// Antecedent a implies consequent c in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> design/x86ild_pkg.sv
`default_nettype none
package x86ild_pkg;
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_LEAD  = 4'd1;
    localparam logic [3:0] PH_OPC   = 4'd2;
    localparam logic [3:0] PH_MAP0F = 4'd3;
    localparam logic [3:0] PH_SKIP  = 4'd4;
    localparam logic [3:0] PH_MODRM = 4'd5;
    localparam logic [3:0] PH_SIB   = 4'd6;
    localparam logic [3:0] PH_TAIL  = 4'd7;

    localparam logic CFG_MIN_BYTES = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    localparam logic [15:0] MODRM_ROWS [16] = '{
        16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0000, 16'h0000, 16'h0A08, 16'h0000,
        16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h00C3, 16'hFF0F, 16'h0000, 16'hC0C8
    };

    typedef struct packed {
        logic [4:0] instruction_length;
        logic [8:0] end_offset;
        logic       boundary_found;
        logic       search_failed;
    } t_result;

    function automatic logic f_is_prefix(input logic [7:0] b);
        case (b)
            8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66,
            8'h67: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic f_has_modrm(input logic [7:0] op);
        logic [15:0] row;
        row = MODRM_ROWS[op[7:4]];
        return row[op[3:0]];
    endfunction

    function automatic logic [3:0] f_plain_imm(input logic [7:0] op, input logic rex_w);
        logic [3:0] r;
        r = 4'd0;
        if (op < 8'h40) begin
            if (op[2:0] == 3'd4) r = 4'd1;
            else if (op[2:0] == 3'd5) r = 4'd4;
        end else if (op == 8'h68) r = 4'd4;
        else if (op == 8'h6A) r = 4'd1;
        else if (op inside {[8'h70:8'h7F]}) r = 4'd1;
        else if (op inside {[8'hA0:8'hA3]}) r = 4'd8;
        else if (op inside {[8'hB0:8'hB7]}) r = 4'd1;
        else if (op inside {[8'hB8:8'hBF]}) r = rex_w ? 4'd8 : 4'd4;
        else if (op == 8'hC2 || op == 8'hCA) r = 4'd2;
        else if (op == 8'hC8) r = 4'd3;
        else if (op == 8'hCD || op == 8'hD4 || op == 8'hD5) r = 4'd1;
        else if (op inside {[8'hE0:8'hE7]}) r = 4'd1;
        else if (op == 8'hE8 || op == 8'hE9) r = 4'd4;
        else if (op == 8'hEB) r = 4'd1;
        return r;
    endfunction

    function automatic logic [3:0] f_modrm_imm(input logic [7:0] op);
        case (op)
            8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6, 8'h6B, 8'hF6: return 4'd1;
            8'h81, 8'hC7, 8'h69, 8'hF7: return 4'd4;
            default: return 4'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> design/x86ild_core.sv
`default_nettype none
module x86ild_core #(
    parameter int MAX_PREFIXES = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_start,
    input  wire logic [7:0]        i_min_bytes,
    input  wire logic [7:0]        i_max_bytes,
    output      logic              o_done,
    output      x86ild_pkg::t_result o_result
);
    import x86ild_pkg::*;

    logic [3:0] r_phase, n_phase;
    logic [3:0] r_pfx, n_pfx;
    logic       r_rexw, n_rexw;
    logic [7:0] r_opc, n_opc;
    logic [3:0] r_skip, n_skip;
    logic [3:0] r_imm, n_imm;
    logic [4:0] r_ibytes, n_ibytes;
    logic [8:0] r_off, n_off;
    logic       r_act, n_act;

    logic [3:0] p_phase, p_pfx;
    logic       p_rexw, p_act;
    logic [7:0] p_opc;
    logic [3:0] p_skip, p_imm;
    logic [4:0] p_ib;
    logic [8:0] p_off;
    logic       fin;
    logic [3:0] tail_n;
    logic       tail_go;
    logic [3:0] disp;
    logic [8:0] new_off;
    logic       found, failed;

    always_comb begin
        p_phase = r_phase; p_pfx = r_pfx; p_rexw = r_rexw; p_opc = r_opc;
        p_skip = r_skip; p_imm = r_imm; p_ib = r_ibytes; p_off = r_off; p_act = r_act;
        if (i_start) begin
            p_act = 1'b1; p_off = 9'd0; p_phase = PH_LEAD; p_pfx = 4'd0;
            p_rexw = 1'b0; p_opc = 8'd0; p_skip = 4'd0; p_imm = 4'd0; p_ib = 5'd0;
        end
        n_phase = p_phase; n_pfx = p_pfx; n_rexw = p_rexw; n_opc = p_opc;
        n_skip = p_skip; n_imm = p_imm; n_ibytes = p_ib + 5'd1; n_off = p_off;
        n_act = p_act;
        fin = 1'b0; tail_go = 1'b0; tail_n = 4'd0; disp = 4'd0;
        if (p_act) begin
            case (p_phase)
                PH_LEAD, PH_OPC: begin
                    if (p_phase == PH_LEAD && f_is_prefix(i_byte)
                            && p_pfx < 4'(MAX_PREFIXES)) begin
                        n_pfx = p_pfx + 4'd1;
                    end else if (p_phase == PH_LEAD && i_byte[7:4] == 4'h4) begin
                        n_rexw = i_byte[3];
                        n_phase = PH_OPC;
                    end else begin
                        n_opc = i_byte;
                        n_imm = 4'd0;
                        if (i_byte == 8'hC4 || i_byte == 8'hC5 || i_byte == 8'h62) begin
                            n_skip = (i_byte == 8'hC4) ? 4'd3
                                   : ((i_byte == 8'hC5) ? 4'd2 : 4'd4);
                            n_phase = PH_SKIP;
                        end else if (i_byte == 8'h0F) begin
                            n_phase = PH_MAP0F;
                        end else if (f_has_modrm(i_byte)) begin
                            n_imm = f_modrm_imm(i_byte);
                            n_phase = PH_MODRM;
                        end else begin
                            tail_go = 1'b1;
                            tail_n = f_plain_imm(i_byte, p_rexw);
                        end
                    end
                end
                PH_MAP0F: begin
                    if (i_byte == 8'h38 || i_byte == 8'h3A) begin
                        n_skip = 4'd1;
                        n_imm = (i_byte == 8'h3A) ? 4'd1 : 4'd0;
                        n_phase = PH_SKIP;
                    end else if (i_byte[7:4] == 4'h8) begin
                        tail_go = 1'b1; tail_n = 4'd4;
                    end else begin
                        n_imm = 4'd0;
                        n_phase = PH_MODRM;
                    end
                end
                PH_SKIP: begin
                    n_skip = p_skip - 4'd1;
                    if (n_skip == 4'd0) n_phase = PH_MODRM;
                end
                PH_MODRM: begin
                    if ((p_opc == 8'hF6 || p_opc == 8'hF7) && i_byte[5:3] != 3'd0) begin
                        n_imm = 4'd0;
                    end
                    disp = (i_byte[7:6] == 2'd1) ? 4'd1
                         : ((i_byte[7:6] == 2'd2) ? 4'd4 : 4'd0);
                    if (i_byte[7:6] != 2'd3 && i_byte[2:0] == 3'd4) begin
                        n_skip = disp;
                        n_phase = PH_SIB;
                    end else begin
                        if (i_byte[7:6] == 2'd0 && i_byte[2:0] == 3'd5) disp = 4'd4;
                        tail_go = 1'b1; tail_n = disp + n_imm;
                    end
                end
                PH_SIB: begin
                    disp = p_skip;
                    if (disp == 4'd0 && i_byte[2:0] == 3'd5) disp = 4'd4;
                    tail_go = 1'b1; tail_n = disp + p_imm;
                end
                PH_TAIL: begin
                    n_skip = p_skip - 4'd1;
                    if (n_skip == 4'd0) fin = 1'b1;
                end
                default: begin
                    n_phase = PH_LEAD; n_pfx = 4'd0; n_rexw = 1'b0; n_opc = 8'd0;
                    n_skip = 4'd0; n_imm = 4'd0; n_ibytes = 5'd0;
                end
            endcase
            if (tail_go) begin
                if (tail_n == 4'd0) begin
                    fin = 1'b1;
                end else begin
                    n_skip = tail_n; n_imm = 4'd0; n_phase = PH_TAIL;
                end
            end
        end else begin
            n_ibytes = p_ib;
        end
        new_off = p_off + {4'd0, n_ibytes};
        found = new_off >= {1'b0, i_min_bytes};
        failed = !found && new_off >= {1'b0, i_max_bytes};
        if (fin) begin
            n_off = new_off;
            n_phase = (found || failed) ? PH_IDLE : PH_LEAD;
            n_act = !(found || failed);
            n_pfx = 4'd0; n_rexw = 1'b0; n_opc = 8'd0; n_skip = 4'd0;
            n_imm = 4'd0; n_ibytes = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_pfx <= 4'd0; r_rexw <= 1'b0; r_opc <= 8'd0;
            r_skip <= 4'd0; r_imm <= 4'd0; r_ibytes <= 5'd0; r_off <= 9'd0;
            r_act <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_pfx <= n_pfx; r_rexw <= n_rexw; r_opc <= n_opc;
            r_skip <= n_skip; r_imm <= n_imm; r_ibytes <= n_ibytes; r_off <= n_off;
            r_act <= n_act;
        end
    end

    assign o_done = fin;
    assign o_result = '{instruction_length: p_ib + 5'd1,
                        end_offset: new_off, boundary_found: found,
                        search_failed: failed};

    `include "assert_macros.svh"
    `ASSERT_CLK(a_idle_inactive, i_clk, i_rst_n, (r_phase == PH_IDLE) == !r_act, "phase/active mismatch")
    `ASSERT_CLK(a_pfx_limit, i_clk, i_rst_n, r_pfx <= 4'(MAX_PREFIXES), "prefix count overflow")
    `ASSERT_NEXT(a_fin_resets, i_clk, i_rst_n, i_step && fin, r_ibytes == 5'd0, "length not cleared")
endmodule
`default_nettype wire

>>> design/x86_instruction_length_decoder_top.sv
// x86 instruction length decoder.
// Slave stream: one code byte per beat in s_axis_tdata, search start flag in
// s_axis_tuser. A start beat opens a new search at offset zero.
// Master stream: one beat per finished instruction carrying its length and the
// running end offset in m_axis_tdata, and the found/failed flags that close a
// search in m_axis_tuser.
// Configuration channel: index 0 writes min_bytes, index 1 writes max_bytes;
// write only while the block is idle.
// Each accepted byte is decoded in the cycle it is accepted and its result,
// if any, is registered, so m_axis_tvalid rises in the cycle after the input
// beat. Throughput is one byte per cycle when not stalled, set by the single phase machine.
// The input is taken whenever the output register is empty or being drained,
// so a stalled receiver holds the result and back-pressures the input.
// Reset sets min_bytes 5, max_bytes 32, clears the search and drops any
// held result.
`default_nettype none
module x86_instruction_length_decoder_top #(
    parameter int MAX_PREFIXES = 14
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // code_byte
    input  wire logic        s_axis_tuser,   // search_start
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // instruction_length[4:0], end_offset[13:5]
    output      logic [1:0]  m_axis_tuser,   // boundary_found[0], search_failed[1]
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import x86ild_pkg::*;

    logic [7:0] r_min, r_max;
    logic       r_ovalid;
    t_result    r_res;
    logic       step, done;
    t_result    res;

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    x86ild_core #(.MAX_PREFIXES(MAX_PREFIXES)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(s_axis_tdata),
        .i_start(s_axis_tuser), .i_min_bytes(r_min), .i_max_bytes(r_max),
        .o_done(done), .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 8'd5;
            r_max <= 8'd32;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_BYTES: r_min <= i_cfg_data;
                    CFG_MAX_BYTES: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tready) r_ovalid <= step && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && done) r_res <= res;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'b00, r_res.end_offset, r_res.instruction_length};
    assign m_axis_tuser = {r_res.search_failed, r_res.boundary_found};

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output dropped under stall")
    `ASSERT_CLK(a_flags, i_clk, i_rst_n, !(m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1]), "both end flags")
endmodule
`default_nettype wire

>>> test/tb.sv
`default_nettype none
module tb;
    import x86ild_pkg::*;

    localparam int LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = '0;

    x86_instruction_length_decoder_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    logic [7:0] min_len, max_len;
    logic [3:0] phase, n_prefix, skip_left, imm_left;
    logic       rex_w, in_search;
    logic [7:0] opcode;
    logic [4:0] ins_len;
    logic [8:0] offset;

    t_result lengths_due[$];
    int errors = 0;
    int cycles = 0;

    function automatic logic is_prefix_byte(logic [7:0] b);
        return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
               b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == 8'h66 ||
               b == 8'h67;
    endfunction

    function automatic logic takes_modrm(logic [7:0] op);
        logic [15:0] rows [16];
        rows = '{16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0000, 16'h0000, 16'h0A08,
                 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h00C3, 16'hFF0F,
                 16'h0000, 16'hC0C8};
        return rows[op[7:4]][op[3:0]];
    endfunction

    function automatic logic [3:0] imm_without_modrm(logic [7:0] op, logic w);
        if (op < 8'h40)
            return (op[3:0] == 4'd4 || op[3:0] == 4'd12) ? 4'd1 :
                   ((op[3:0] == 4'd5 || op[3:0] == 4'd13) ? 4'd4 : 4'd0);
        if (op == 8'h68) return 4'd4;
        if (op == 8'h6A) return 4'd1;
        if (op >= 8'h70 && op <= 8'h7F) return 4'd1;
        if (op >= 8'hA0 && op <= 8'hA3) return 4'd8;
        if (op >= 8'hB0 && op <= 8'hB7) return 4'd1;
        if (op >= 8'hB8 && op <= 8'hBF) return w ? 4'd8 : 4'd4;
        if (op == 8'hC2 || op == 8'hCA) return 4'd2;
        if (op == 8'hC8) return 4'd3;
        if (op == 8'hCD || op == 8'hD4 || op == 8'hD5) return 4'd1;
        if (op >= 8'hE0 && op <= 8'hE7) return 4'd1;
        if (op == 8'hE8 || op == 8'hE9) return 4'd4;
        if (op == 8'hEB) return 4'd1;
        return 4'd0;
    endfunction

    function automatic logic [3:0] imm_with_modrm(logic [7:0] op);
        if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC0 || op == 8'hC1 ||
            op == 8'hC6 || op == 8'h6B || op == 8'hF6) return 4'd1;
        if (op == 8'h81 || op == 8'hC7 || op == 8'h69 || op == 8'hF7) return 4'd4;
        return 4'd0;
    endfunction

    task automatic open_instruction();
        phase = PH_LEAD;
        n_prefix = 4'd0;
        rex_w = 1'b0;
        opcode = 8'd0;
        skip_left = 4'd0;
        imm_left = 4'd0;
        ins_len = 5'd0;
    endtask

    task automatic close_instruction();
        t_result r;
        offset = offset + {4'd0, ins_len};
        r.instruction_length = ins_len;
        r.end_offset = offset;
        r.boundary_found = offset >= {1'b0, min_len};
        r.search_failed = !r.boundary_found && offset >= {1'b0, max_len};
        lengths_due.push_back(r);
        open_instruction();
        if (r.boundary_found || r.search_failed) begin
            in_search = 1'b0;
            phase = PH_IDLE;
        end
    endtask

    task automatic go_tail(logic [3:0] n);
        if (n == 4'd0) begin
            close_instruction();
        end else begin
            skip_left = n;
            imm_left = 4'd0;
            phase = PH_TAIL;
        end
    endtask

    task automatic take_opcode(logic [7:0] b);
        opcode = b;
        imm_left = 4'd0;
        if (b == 8'hC4 || b == 8'hC5 || b == 8'h62) begin
            skip_left = (b == 8'hC4) ? 4'd3 : ((b == 8'hC5) ? 4'd2 : 4'd4);
            phase = PH_SKIP;
        end else if (b == 8'h0F) begin
            phase = PH_MAP0F;
        end else if (takes_modrm(b)) begin
            imm_left = imm_with_modrm(b);
            phase = PH_MODRM;
        end else begin
            go_tail(imm_without_modrm(b, rex_w));
        end
    endtask

    task automatic predict_byte(logic [7:0] b, logic start);
        logic [3:0] disp;
        if (start) begin
            in_search = 1'b1;
            offset = 9'd0;
            open_instruction();
        end
        if (in_search) begin
            ins_len = ins_len + 5'd1;
            case (phase)
                PH_LEAD: begin
                    if (is_prefix_byte(b) && n_prefix < 4'd14) begin
                        n_prefix = n_prefix + 4'd1;
                    end else if (b[7:4] == 4'h4) begin
                        rex_w = b[3];
                        phase = PH_OPC;
                    end else begin
                        take_opcode(b);
                    end
                end
                PH_OPC: take_opcode(b);
                PH_MAP0F: begin
                    if (b == 8'h38 || b == 8'h3A) begin
                        skip_left = 4'd1;
                        imm_left = (b == 8'h3A) ? 4'd1 : 4'd0;
                        phase = PH_SKIP;
                    end else if (b >= 8'h80 && b <= 8'h8F) begin
                        go_tail(4'd4);
                    end else begin
                        imm_left = 4'd0;
                        phase = PH_MODRM;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 4'd1;
                    if (skip_left == 4'd0) phase = PH_MODRM;
                end
                PH_MODRM: begin
                    if ((opcode == 8'hF6 || opcode == 8'hF7) && b[5:3] != 3'd0)
                        imm_left = 4'd0;
                    disp = (b[7:6] == 2'd1) ? 4'd1 : ((b[7:6] == 2'd2) ? 4'd4 : 4'd0);
                    if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
                        skip_left = disp;
                        phase = PH_SIB;
                    end else begin
                        if (b[7:6] == 2'd0 && b[2:0] == 3'd5) disp = 4'd4;
                        go_tail(disp + imm_left);
                    end
                end
                PH_SIB: begin
                    disp = skip_left;
                    if (disp == 4'd0 && b[2:0] == 3'd5) disp = 4'd4;
                    go_tail(disp + imm_left);
                end
                PH_TAIL: begin
                    skip_left = skip_left - 4'd1;
                    if (skip_left == 4'd0) close_instruction();
                end
                default: open_instruction();
            endcase
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic start);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b, start);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (lengths_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MIN_BYTES) min_len = val; else max_len = val;
    endtask

    // Receiver stalls and result checking.
    initial begin
        int stall;
        t_result want, got;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.instruction_length = m_axis_tdata[4:0];
                got.end_offset = m_axis_tdata[13:5];
                got.boundary_found = m_axis_tuser[0];
                got.search_failed = m_axis_tuser[1];
                if (lengths_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat %h %h", m_axis_tdata, m_axis_tuser);
                end else begin
                    want = lengths_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] pick_prefix();
        logic [7:0] p [11];
        p = '{8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67};
        return p[$urandom_range(0, 10)];
    endfunction

    // Sends one instruction with random prefixes, REX, opcode and following bytes.
    task automatic send_instruction(logic start);
        int np, kind, k;
        logic [7:0] op, modrm;
        logic first;
        first = start;
        np = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        repeat (np) begin
            send_byte(pick_prefix(), first);
            first = 1'b0;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_byte(8'h40 | 8'($urandom_range(0, 15)), first);
            first = 1'b0;
        end
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            op = ($urandom_range(0, 2) == 0) ? 8'hC4 : (($urandom_range(0, 1)) ? 8'hC5 : 8'h62);
            send_byte(op, first);
            k = (op == 8'hC4) ? 3 : ((op == 8'hC5) ? 2 : 4);
            repeat (k) send_byte(8'($urandom), 1'b0);
        end else if (kind == 1) begin
            send_byte(8'h0F, first);
            k = $urandom_range(0, 3);
            op = (k == 0) ? 8'h38 : ((k == 1) ? 8'h3A : 8'($urandom));
            send_byte(op, 1'b0);
            if (op == 8'h38 || op == 8'h3A) send_byte(8'($urandom), 1'b0);
        end else begin
            send_byte(8'($urandom), first);
        end
        // Bytes past the opcode; the predictor decides when the instruction ends.
        repeat (20) begin
            if (phase == PH_LEAD || phase == PH_IDLE) break;
            modrm = 8'($urandom);
            send_byte(modrm, 1'b0);
        end
    endtask

    task automatic send_search(int n_ins);
        send_instruction(1'b1);
        for (int j = 1; j < n_ins && in_search; j++) send_instruction(1'b0);
    endtask

    task automatic test_directed();
        logic [7:0] seq [];
        // Extremes, maps, VEX/EVEX, SIB, long prefix chains, second REX, prefix after REX.
        seq = '{8'h90, 8'hFF, 8'h00, 8'hC0, 8'h66, 8'h48, 8'hB8, 8'h01, 8'h02, 8'h03,
                8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h41, 8'h42, 8'h48, 8'h66,
                8'hF7, 8'h44, 8'h24, 8'h10, 8'hAA, 8'hBB};
        for (int j = 0; j < seq.size(); j++) send_byte(seq[j], j == 0);
        for (int j = 0; j < 16; j++) send_byte(8'hF3, j == 0);
        send_byte(8'h0F, 1); send_byte(8'h3A, 0); send_byte(8'h0F, 0); send_byte(8'h04, 0);
        send_byte(8'h55, 0); send_byte(8'h0F, 1); send_byte(8'h85, 0);
        send_byte(8'hC4, 0);
        send_byte(8'h12, 0);
        send_byte(8'hF6, 1); send_byte(8'h08, 0);
        send_byte(8'hF7, 1); send_byte(8'h00, 0);
        send_byte(8'h62, 1);
        send_byte(8'h90, 0);
        send_byte(8'h90, 1);
        send_byte(8'h90, 0);
        send_byte(8'h90, 0);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MIN_BYTES, 8'd0);
        write_reg(CFG_MAX_BYTES, 8'd0);
        repeat (10) send_search(3);
        write_reg(CFG_MIN_BYTES, 8'd255);
        write_reg(CFG_MAX_BYTES, 8'd255);
        repeat (2) send_search(200);
        write_reg(CFG_MIN_BYTES, 8'd255);
        write_reg(CFG_MAX_BYTES, 8'd1);
        repeat (10) send_search(3);
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MIN_BYTES, 8'($urandom_range(0, 40)));
            write_reg(CFG_MAX_BYTES, 8'($urandom_range(1, 60)));
            repeat (12) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 12))
                        send_byte(8'($urandom), $urandom_range(0, 5) == 0);
                end else begin
                    send_search($urandom_range(1, 10));
                end
            end
            if (p == 2) drain();
        end
    endtask

    initial begin
        min_len = 8'd5;
        max_len = 8'd32;
        in_search = 1'b0;
        offset = 9'd0;
        open_instruction();
        phase = PH_IDLE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> x86_instruction_length_decoder_top.f
+incdir+design
design/x86ild_pkg.sv
design/x86ild_core.sv
design/x86_instruction_length_decoder_top.sv
test/tb.sv
